### rtl/spfs_pkg.sv
// Package for the smallest-prime-factor sieve block.
// Holds field widths, result status codes, sequencer states and divider structs.
// No dependencies.
`default_nettype none

package spfs_pkg;

  // Width of every value field on the ports
  localparam int VAL_W = 17;
  localparam int CNT_W = $clog2(VAL_W + 1);

  // Result status codes
  localparam logic [1:0] ST_SPLIT    = 2'd0;
  localparam logic [1:0] ST_NO_SPLIT = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_BUILT    = 2'd3;

  // Input kind codes
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Reset value of the limit register
  localparam logic [VAL_W-1:0] LIMIT_RST = 17'h10000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_BRD,
    S_BCHK,
    S_BPRD,
    S_BMUL,
    S_BMARK,
    S_BNEXT,
    S_QLK,
    S_QDIV,
    S_DONE
  } seq_state_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
    logic [VAL_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/spfs_if.sv
// Valid/ready channel interfaces for the sieve block: request and result.
// Depends on spfs_pkg.
`default_nettype none

interface spfs_in_if;
  import spfs_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [VAL_W-1:0] query_value;
  modport source (output valid, kind, query_value, input ready);
  modport sink   (input valid, kind, query_value, output ready);
endinterface

interface spfs_out_if;
  import spfs_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [VAL_W-1:0] cofactor;
  logic [VAL_W-1:0] smallest_factor;
  modport source (output valid, status, cofactor, smallest_factor, input ready);
  modport sink   (input valid, status, cofactor, smallest_factor, output ready);
endinterface

`default_nettype wire

### rtl/smallest_prime_factor_sieve_split.sv
// Top level: linear sieve builder and query splitter over a smallest-factor table.
// Depends on spfs_pkg, spfs_if and spfs_div.
//
//   channel | dir | handshake        | payload
//   in_ch   | in  | valid/ready      | kind, query_value
//   out_ch  | out | valid/ready      | status, cofactor, smallest_factor
//   cfg     | in  | cfg_wr_en        | cfg_wr_data (sieve limit)
//
// Build: clears table entries 0..L, then each value passes the read, check and next
//   states, with a multiply and a mark state per prime tried against it.
// Query: table lookup, then divisions by p on the divider
//   (one more than the power of p), then the result goes to the output register.
// One transaction is in work at a time; in_ch.ready is high only when idle.
// A finished result waits in the output register; the sequencer holds in its
//   done state while the output register is still occupied.
// Reset is synchronous, active low; the table is considered unbuilt after reset.
`default_nettype none

module smallest_prime_factor_sieve_split #(
  parameter int MAX_VALUE   = 65536,
  parameter int PRIME_DEPTH = 8192
) (
  input  wire                        clk,
  input  wire                        rst_n,
  spfs_in_if.sink                    in_ch,
  spfs_out_if.source                 out_ch,
  input  wire                        cfg_wr_en,
  input  wire [spfs_pkg::VAL_W-1:0]  cfg_wr_data
);
  import spfs_pkg::*;

  localparam int AW = $clog2(MAX_VALUE + 1);
  localparam int PW = $clog2(PRIME_DEPTH);
  localparam int CW = $clog2(PRIME_DEPTH + 1);

  // Memories
  logic [VAL_W-1:0] ft_mem [0:MAX_VALUE];
  logic [VAL_W-1:0] pl_mem [0:PRIME_DEPTH-1];
  logic [VAL_W-1:0] ft_q, pl_q;
  logic             ft_we, pl_we;
  logic [AW-1:0]    ft_waddr, ft_raddr;
  logic [VAL_W-1:0] ft_wdata;
  logic [PW-1:0]    pl_raddr;

  // Control and datapath registers
  seq_state_t         state_r, state_nxt;
  logic [VAL_W-1:0]   cfg_lim_r;
  logic [VAL_W-1:0]   lim_r, lim_nxt;
  logic [VAL_W-1:0]   built_lim_r, built_lim_nxt;
  logic               built_r, built_nxt;
  logic [VAL_W-1:0]   i_r, i_nxt;
  logic [VAL_W-1:0]   spf_r, spf_nxt;
  logic [VAL_W-1:0]   p_r, p_nxt;
  logic [VAL_W-1:0]   x_r, x_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      pc_r, pc_nxt;
  logic [2*VAL_W-1:0] prod_r, prod_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic [VAL_W-1:0]   res_cof_r, res_cof_nxt;
  logic [VAL_W-1:0]   res_fac_r, res_fac_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_st_r;
  logic [VAL_W-1:0]   out_cof_r, out_fac_r;
  logic               out_load;
  logic [VAL_W-1:0]   lim_clamp;
  logic               in_acc;

  div_req_t div_req;
  div_rsp_t div_rsp;

  spfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Limit register clamped to [2, MAX_VALUE]
  always_comb begin
    if (32'(cfg_lim_r) > MAX_VALUE) lim_clamp = VAL_W'(MAX_VALUE);
    else if (cfg_lim_r < VAL_W'(2)) lim_clamp = VAL_W'(2);
    else                            lim_clamp = cfg_lim_r;
  end

  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    lim_nxt       = lim_r;
    built_lim_nxt = built_lim_r;
    built_nxt     = built_r;
    i_nxt         = i_r;
    spf_nxt       = spf_r;
    p_nxt         = p_r;
    x_nxt         = x_r;
    k_nxt         = k_r;
    pc_nxt        = pc_r;
    prod_nxt      = prod_r;
    res_st_nxt    = res_st_r;
    res_cof_nxt   = res_cof_r;
    res_fac_nxt   = res_fac_r;
    out_load      = 1'b0;
    ft_we         = 1'b0;
    ft_waddr      = AW'(i_r);
    ft_wdata      = '0;
    ft_raddr      = AW'(i_r);
    pl_we         = 1'b0;
    pl_raddr      = k_r[PW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = x_r;
    div_req.divisor  = p_r;

    unique case (state_r)
      S_IDLE: begin
        ft_raddr = AW'(in_ch.query_value);
        if (in_acc) begin
          res_st_nxt  = ST_INVALID;
          res_cof_nxt = '0;
          res_fac_nxt = '0;
          x_nxt       = in_ch.query_value;
          if (in_ch.kind == KIND_BUILD) begin
            lim_nxt   = lim_clamp;
            i_nxt     = '0;
            state_nxt = S_CLR;
          end else if (!built_r || in_ch.query_value < VAL_W'(2) ||
                       in_ch.query_value > built_lim_r) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_QLK;
          end
        end
      end
      // clear entries 0..L
      S_CLR: begin
        ft_we = 1'b1;
        if (i_r == lim_r) begin
          i_nxt     = VAL_W'(2);
          pc_nxt    = '0;
          state_nxt = S_BRD;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_BRD: begin
        state_nxt = S_BCHK;
      end
      // unmarked value is a new prime
      S_BCHK: begin
        k_nxt     = '0;
        state_nxt = S_BPRD;
        if (ft_q == '0) begin
          ft_we    = 1'b1;
          ft_wdata = i_r;
          spf_nxt  = i_r;
          if (pc_r != CW'(PRIME_DEPTH)) begin
            pl_we  = 1'b1;
            pc_nxt = pc_r + 1'b1;
          end
        end else begin
          spf_nxt = ft_q;
        end
      end
      S_BPRD: begin
        if (k_r < pc_r) state_nxt = S_BMUL;
        else            state_nxt = S_BNEXT;
      end
      S_BMUL: begin
        p_nxt     = pl_q;
        prod_nxt  = i_r * pl_q;
        state_nxt = S_BMARK;
      end
      // mark i*p; stop at the smallest factor of i
      S_BMARK: begin
        if (prod_r > {{VAL_W{1'b0}}, lim_r}) begin
          state_nxt = S_BNEXT;
        end else begin
          ft_we    = 1'b1;
          ft_waddr = AW'(prod_r);
          ft_wdata = p_r;
          if (p_r == spf_r) begin
            state_nxt = S_BNEXT;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_BPRD;
          end
        end
      end
      S_BNEXT: begin
        if (i_r == lim_r) begin
          built_nxt     = 1'b1;
          built_lim_nxt = lim_r;
          res_st_nxt    = ST_BUILT;
          state_nxt     = S_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_BRD;
        end
      end
      // table lookup, start first division
      S_QLK: begin
        if (ft_q < VAL_W'(2)) begin
          state_nxt = S_DONE;
        end else begin
          p_nxt            = ft_q;
          div_req.start    = 1'b1;
          div_req.dividend = x_r;
          div_req.divisor  = ft_q;
          state_nxt        = S_QDIV;
        end
      end
      // divide out p while it divides evenly
      S_QDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            x_nxt            = div_rsp.quot;
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quot;
            div_req.divisor  = p_r;
          end else begin
            state_nxt = S_DONE;
            if (x_r == VAL_W'(1)) begin
              res_st_nxt = ST_NO_SPLIT;
            end else begin
              res_st_nxt  = ST_SPLIT;
              res_cof_nxt = x_r;
              res_fac_nxt = p_r;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (out_load)     out_valid_nxt = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_lim_r   <= LIMIT_RST;
      built_r     <= 1'b0;
      built_lim_r <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      built_lim_r <= built_lim_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) cfg_lim_r <= cfg_wr_data;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lim_r     <= lim_nxt;
    i_r       <= i_nxt;
    spf_r     <= spf_nxt;
    p_r       <= p_nxt;
    x_r       <= x_nxt;
    k_r       <= k_nxt;
    prod_r    <= prod_nxt;
    res_st_r  <= res_st_nxt;
    res_cof_r <= res_cof_nxt;
    res_fac_r <= res_fac_nxt;
    if (out_load) begin
      out_st_r  <= res_st_r;
      out_cof_r <= res_cof_r;
      out_fac_r <= res_fac_r;
    end
  end

  // Factor table and prime list
  always_ff @(posedge clk) begin
    if (ft_we) ft_mem[ft_waddr] <= ft_wdata;
    ft_q <= ft_mem[ft_raddr];
  end

  always_ff @(posedge clk) begin
    if (pl_we) pl_mem[pc_r[PW-1:0]] <= i_r;
    pl_q <= pl_mem[pl_raddr];
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_st_r;
  assign out_ch.cofactor        = out_cof_r;
  assign out_ch.smallest_factor = out_fac_r;

`ifndef SYNTHESIS
  a_zero_unless_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r != ST_SPLIT |-> out_cof_r == '0 && out_fac_r == '0)
    else $error("nonzero payload on a result without split");

  a_split_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r == ST_SPLIT |-> out_cof_r >= VAL_W'(2) &&
      out_fac_r >= VAL_W'(2))
    else $error("split result with factor or cofactor below two");

  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pc_r) <= PRIME_DEPTH)
    else $error("prime count exceeds list depth");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_QDIV)
    else $error("divider finished outside the query loop");

  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BMARK && ft_we |-> prod_r <= {{VAL_W{1'b0}}, lim_r})
    else $error("sieve marks beyond the build limit");
`endif

endmodule

`default_nettype wire

### rtl/spfs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on spfs_pkg.
`default_nettype none

module spfs_div (
  input  wire                clk,
  input  wire                rst_n,
  input  spfs_pkg::div_req_t req,
  output spfs_pkg::div_rsp_t rsp
);
  import spfs_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VAL_W-1:0]   rem_r, rem_nxt;
  logic [VAL_W-1:0]   quo_r, quo_nxt;
  logic [VAL_W-1:0]   dvs_r, dvs_nxt;
  logic [VAL_W:0]     trial;
  logic               ge;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r, quo_r[VAL_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VAL_W);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? VAL_W'(trial - {1'b0, dvs_r}) : trial[VAL_W-1:0];
      quo_nxt = {quo_r[VAL_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking bench for smallest_prime_factor_sieve_split: a linear sieve rebuilt
// in the bench predicts each build and split query; results are checked in order.
// Depends on spfs_pkg and spfs_if (rtl) and the block itself.
`timescale 1ns / 100ps

module tb;
  import spfs_pkg::*;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] value;
  } sieve_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] cofactor;
    logic [VAL_W-1:0] factor;
  } split_res_t;

  localparam int MAX_VAL   = 65536;
  localparam int PRIME_CAP = 8192;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [VAL_W-1:0]     cfg_wr_data;

  spfs_in_if  req_ch ();
  spfs_out_if res_ch ();

  smallest_prime_factor_sieve_split uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (req_ch),
    .out_ch     (res_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Bench copy of the sieve state
  int unsigned spf_tab [0:MAX_VAL];
  int unsigned prime_tab [0:PRIME_CAP-1];
  int unsigned prime_num;
  bit          tab_ready;
  int unsigned tab_limit;
  int unsigned limit_reg;

  sieve_req_t  req_q [$];
  split_res_t  split_exp_q [$];
  int          err_cnt;
  int          build_cnt;
  int          query_cnt;
  bit          calm;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Linear sieve over 2..clamped limit
  task automatic sieve_rebuild();
    int unsigned lim;
    longint unsigned m;
    lim = limit_reg;
    if (lim < 2) lim = 2;
    if (lim > MAX_VAL) lim = MAX_VAL;
    for (int j = 0; j <= MAX_VAL; j++) spf_tab[j] = 0;
    prime_num = 0;
    for (int unsigned i = 2; i <= lim; i++) begin
      if (spf_tab[i] == 0) begin
        spf_tab[i] = i;
        if (prime_num < PRIME_CAP) begin
          prime_tab[prime_num] = i;
          prime_num++;
        end
      end
      for (int unsigned k = 0; k < prime_num; k++) begin
        m = longint'(i) * longint'(prime_tab[k]);
        if (m > lim) break;
        spf_tab[m] = prime_tab[k];
        if (i % prime_tab[k] == 0) break;
      end
    end
    tab_limit = lim;
    tab_ready = 1'b1;
  endtask

  // Expected result of one accepted transaction
  task automatic predict_split(input sieve_req_t r);
    split_res_t  res;
    int unsigned x, p;
    res = '{status: ST_INVALID, cofactor: '0, factor: '0};
    x = r.value;
    if (r.kind == KIND_BUILD) begin
      sieve_rebuild();
      res.status = ST_BUILT;
      build_cnt++;
    end else begin
      query_cnt++;
      if (tab_ready && x >= 2 && x <= tab_limit && spf_tab[x] >= 2) begin
        p = spf_tab[x];
        while (x % p == 0) x = x / p;
        if (x == 1) res.status = ST_NO_SPLIT;
        else begin
          res.status   = ST_SPLIT;
          res.cofactor = VAL_W'(x);
          res.factor   = VAL_W'(p);
        end
      end
    end
    split_exp_q.insert(split_exp_q.size(), res);
  endtask

  // Mostly short gaps, a few long ones; calm stretches have none
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 199) == 0) calm = ~calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Request driver
  sieve_req_t cur_req;
  bit         drv_busy;
  int         drv_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      drv_busy = 1'b0;
      drv_gap  = 0;
    end else begin
      if (drv_busy && req_ch.ready) begin
        predict_split(cur_req);
        drv_busy = 1'b0;
        drv_gap  = pick_gap();
      end
      if (!drv_busy) begin
        if (drv_gap > 0) drv_gap--;
        else if (req_q.size() > 0) begin
          cur_req  = req_q.pop_front();
          drv_busy = 1'b1;
        end
      end
      req_ch.valid       <= drv_busy;
      req_ch.kind        <= cur_req.kind;
      req_ch.query_value <= cur_req.value;
    end
  end

  // Result monitor with random back-pressure
  int stall_left;
  always @(posedge clk) begin
    split_res_t e;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (split_exp_q.size() == 0) begin
          $error("unexpected result transaction, status %0d", res_ch.status);
          err_cnt++;
        end else begin
          e = split_exp_q.pop_front();
          if (res_ch.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, res_ch.status);
            err_cnt++;
          end
          if (res_ch.cofactor !== e.cofactor) begin
            $error("cofactor: expected %0d, actual %0d", e.cofactor, res_ch.cofactor);
            err_cnt++;
          end
          if (res_ch.smallest_factor !== e.factor) begin
            $error("smallest_factor: expected %0d, actual %0d", e.factor,
                   res_ch.smallest_factor);
            err_cnt++;
          end
        end
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_req(input logic kind, input int unsigned v);
    sieve_req_t r;
    r.kind  = kind;
    r.value = v[VAL_W-1:0];
    req_q.insert(req_q.size(), r);
  endtask

  // Wait until every transaction is accepted and answered
  task automatic wait_idle();
    do @(negedge clk);
    while (req_q.size() != 0 || req_ch.valid || split_exp_q.size() != 0);
  endtask

  task automatic write_limit(input int unsigned v);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[VAL_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_reg = v & 32'h1FFFF;
  endtask

  // Stimulus
  initial begin
    int unsigned lim, nq, r;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_QUERY;
    req_ch.query_value = '0;
    res_ch.ready = 1'b0;
    cur_req      = '0;
    err_cnt = 0; build_cnt = 0; query_cnt = 0; calm = 1'b0;
    prime_num = 0; tab_ready = 1'b0; tab_limit = 0; limit_reg = 32'(LIMIT_RST);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Queries before any build
    push_req(KIND_QUERY, 10);
    push_req(KIND_QUERY, 0);
    push_req(KIND_QUERY, 131071);
    // Limit above the maximum clamps to a full table
    write_limit(131071);
    push_req(KIND_BUILD, 0);
    push_req(KIND_QUERY, 0);
    push_req(KIND_QUERY, 1);
    push_req(KIND_QUERY, 2);
    push_req(KIND_QUERY, 4);
    push_req(KIND_QUERY, 12);
    push_req(KIND_QUERY, 65535);
    push_req(KIND_QUERY, 65536);
    push_req(KIND_QUERY, 65521);
    push_req(KIND_QUERY, 65537);
    push_req(KIND_QUERY, 131071);
    // New limit without a build keeps the old table
    write_limit(20);
    push_req(KIND_QUERY, 65535);
    // Limit below two clamps to two
    write_limit(0);
    push_req(KIND_BUILD, 0);
    push_req(KIND_QUERY, 2);
    push_req(KIND_QUERY, 3);
    write_limit(1);
    push_req(KIND_BUILD, 0);
    push_req(KIND_QUERY, 2);

    // Random phases: small tables, mostly in-range queries
    while (build_cnt + query_cnt + req_q.size() < 2000) begin
      r = $urandom_range(0, 19);
      if (r == 0) lim = $urandom_range(0, 3);
      else if (r == 1) lim = 65536 + $urandom_range(0, 65535);
      else lim = $urandom_range(2, 400);
      if (r == 1) lim = $urandom_range(2, 1200);
      write_limit(lim);
      if ($urandom_range(0, 7) != 0) push_req(KIND_BUILD, $urandom_range(0, 131071));
      nq = $urandom_range(15, 45);
      for (int q = 0; q < nq; q++) begin
        r = $urandom_range(0, 9);
        if (r < 8) push_req(KIND_QUERY, $urandom_range(0, tab_limit + 2));
        else push_req(KIND_QUERY, $urandom_range(0, 131071));
      end
      // occasional limit change with no rebuild
      if ($urandom_range(0, 4) == 0) begin
        write_limit($urandom_range(0, 131071));
        for (int q = 0; q < 8; q++) push_req(KIND_QUERY, $urandom_range(0, tab_limit + 2));
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Covered %0d table builds and %0d split queries, clamped and small limits,",
             build_cnt, query_cnt);
    $display("with random gaps on requests and random back-pressure on results.");
    if (err_cnt == 0 && split_exp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit: one full-table build plus all queries, several times over
  initial begin
    #60000000;
    $display("timeout with %0d results outstanding", split_exp_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
